// File: hw/rtl/wcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcf_pkg
// Shared constants, types and codes of the window convolution filter.
// ----------------------------------------------------------------------------
package wcf_pkg;

	localparam int TAPS    = 7;
	localparam int LINES   = (TAPS > 1) ? TAPS - 1 : 1;
	localparam int NCOEF   = TAPS * TAPS;
	localparam int DIM     = 64;
	localparam int FRAC    = 12;

	localparam int DIM_W   = 7;
	localparam int POS_W   = 6;
	localparam int KS_W    = 3;
	localparam int CIDX_W  = 6;
	localparam int SLOT_W  = $clog2(LINES);
	localparam int PIX_W   = 13;
	localparam int SMP_W   = 14;
	localparam int OUT_W   = 18;
	localparam int PROD_W  = PIX_W + 1 + SMP_W;
	localparam int ROWS_W  = PROD_W + 3;
	localparam int SUM_W   = ROWS_W + 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_COEF  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_KSIZE  = 2'd2,
		REG_FLIP   = 2'd3
	} cfg_reg_t;

	typedef logic [PIX_W-1:0]         pix_t;
	typedef logic signed [SMP_W-1:0]  coef_t;
	typedef logic [SLOT_W-1:0]        slot_t;
	typedef logic [LINES-1:0][PIX_W-1:0] line_word_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} tag_t;

endpackage

// File: hw/rtl/wcf_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcf channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface wcf_in_if import wcf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [CIDX_W-1:0]        coef_index;
	logic signed [SMP_W-1:0]  sample;

	modport source (output valid, action, coef_index, sample, input ready);
	modport sink (input valid, action, coef_index, sample, output ready);
endinterface

interface wcf_out_if import wcf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [OUT_W-1:0]  filtered;
	logic [POS_W-1:0]         out_row;
	logic [POS_W-1:0]         out_col;
	logic                     frame_done;

	modport source (output valid, filtered, out_row, out_col, frame_done, input ready);
	modport sink (input valid, filtered, out_row, out_col, frame_done, output ready);
endinterface

interface wcf_cfg_if import wcf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/wcf_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcf_line_buf
// Line store: one word per column holding that column of every stored row.
// ----------------------------------------------------------------------------
module wcf_line_buf import wcf_pkg::*; (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [POS_W-1:0] wr_col,
	input  slot_t            wr_slot,
	input  pix_t             wr_data,
	input  logic             rd_en,
	input  logic [POS_W-1:0] rd_col,
	output line_word_t       rd_data
);

	line_word_t mem [DIM];

	// read returns the word as it was before this cycle's write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_col][wr_slot] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_col];
		end
	end

endmodule

// File: hw/rtl/wcf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcf_mac
// Multiply, row sums, total with rounding, then shift and saturate.
// ----------------------------------------------------------------------------
module wcf_mac import wcf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  tag_t                    in_tag,
	input  pix_t                    win [TAPS][TAPS],
	input  coef_t                   lane_coef [TAPS][TAPS],
	output logic                    out_valid,
	output logic signed [OUT_W-1:0] out_filtered,
	output tag_t                    out_tag
);

	localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (FRAC - 1);
	localparam logic signed [SUM_W-1:0] OMAX = SUM_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] OMIN = -(SUM_W'(1) <<< (OUT_W - 1));

	logic                       valid_s3, valid_s4, valid_s5;
	tag_t                       tag_s3, tag_s4, tag_s5;
	logic signed [PROD_W-1:0]   prod_s3 [TAPS][TAPS];
	logic signed [ROWS_W-1:0]   rsum_s4 [TAPS];
	logic signed [SUM_W-1:0]    total_s5;
	logic signed [ROWS_W-1:0]   rsum_c [TAPS];
	logic signed [SUM_W-1:0]    total_c;
	logic signed [SUM_W-1:0]    shifted_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s3  <= in_valid;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			out_valid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < TAPS; q++) begin
				for (int p = 0; p < TAPS; p++) begin
					prod_s3[q][p] <= PROD_W'($signed({1'b0, win[q][p]}) * lane_coef[q][p]);
				end
			end
			tag_s3 <= in_tag;
		end
	end

	always_comb begin
		for (int q = 0; q < TAPS; q++) begin
			rsum_c[q] = '0;
			for (int p = 0; p < TAPS; p++) begin
				rsum_c[q] = rsum_c[q] + ROWS_W'(prod_s3[q][p]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsum_s4 <= rsum_c;
			tag_s4  <= tag_s3;
		end
	end

	always_comb begin
		total_c = RND;
		for (int q = 0; q < TAPS; q++) begin
			total_c = total_c + SUM_W'(rsum_s4[q]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_s5 <= total_c;
			tag_s5   <= tag_s4;
		end
	end

	// arithmetic shift gives the floor of the rounded quotient
	assign shifted_c = total_s5 >>> FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			if (shifted_c > OMAX) begin
				out_filtered <= OMAX[OUT_W-1:0];
			end else if (shifted_c < OMIN) begin
				out_filtered <= OMIN[OUT_W-1:0];
			end else begin
				out_filtered <= shifted_c[OUT_W-1:0];
			end
			out_tag <= tag_s5;
		end
	end

endmodule

// File: hw/rtl/window_convolution_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_convolution_filter
// Streaming square-kernel filter over a raster frame with line buffers.
// ----------------------------------------------------------------------------
// Usage:
//   cfg     : register writes (width, height, kernel size, flip), always ready;
//             write only while the pipeline is empty
//   pixels  : one transaction per pixel in raster order (action 0) or per
//             coefficient write (action 1, index row*7+column, Q12)
//   results : one transaction per pixel that completes a full window, tagged
//             with the window centre and the last-result-of-frame flag
// Throughput is one pixel per cycle while results is ready. An accepted
// pixel reaches its result through six registers: line-store read, window
// shift, multiply, row sums, total, saturate into the output register.
// A coefficient write travels down the pipe and lands in the table at the
// multiply stage, so it only affects pixels that follow it.
// Reset clears counters, window, coefficients and config to defaults; the
// line store holds garbage until rows are written.
// When results stalls, the whole pipe holds and pixels is not ready; no
// transaction is lost or repeated.
// ----------------------------------------------------------------------------
module window_convolution_filter import wcf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	wcf_cfg_if.sink    cfg,
	wcf_in_if.sink     pixels,
	wcf_out_if.source  results
);

	logic [DIM_W-1:0] width_q, height_q;
	logic [KS_W-1:0]  ksize_q;
	logic             flip_q;

	logic [POS_W-1:0] row_q, col_q;
	slot_t            slot_q;

	logic [DIM_W-1:0] w_eff, h_eff, k7;
	logic [KS_W-1:0]  k_eff;
	logic [DIM_W-1:0] cw, rw, nc, nr;
	slot_t            sl, nsl;
	logic             emit_c;
	tag_t             tag_c;
	pix_t             pix_c;

	logic en, acc, acc_pix;

	logic             valid_s1, act_s1, emit_s1;
	logic [CIDX_W-1:0] cidx_s1;
	coef_t            coef_s1;
	pix_t             pix_s1;
	slot_t            slot_s1;
	tag_t             tag_s1;
	line_word_t       rd_s1;
	pix_t             newcol [TAPS];

	logic             valid_s2, act_s2, emit_s2;
	logic [CIDX_W-1:0] cidx_s2;
	coef_t            coef_s2;
	tag_t             tag_s2;

	pix_t             window_q [TAPS][TAPS];
	pix_t             win_c [TAPS][TAPS];
	coef_t            coef_q [NCOEF];
	coef_t            lane_coef [TAPS][TAPS];

	logic                    mac_valid;
	logic signed [OUT_W-1:0] mac_filtered;
	tag_t                    mac_tag;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(21);
			height_q <= DIM_W'(21);
			ksize_q  <= KS_W'(3);
			flip_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_WIDTH:  width_q  <= cfg.data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[DIM_W-1:0];
				REG_KSIZE:  ksize_q  <= cfg.data[KS_W-1:0];
				REG_FLIP:   flip_q   <= cfg.data[0];
			endcase
		end
	end

	assign w_eff = (width_q == '0) ? DIM_W'(1) : (width_q > DIM_W'(DIM)) ? DIM_W'(DIM) : width_q;
	assign h_eff = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(DIM)) ? DIM_W'(DIM) : height_q;
	assign k_eff = (ksize_q == '0) ? KS_W'(1) : ksize_q;
	assign k7    = DIM_W'(k_eff);

	// handshake: the whole pipe moves together
	assign en            = !mac_valid || results.ready;
	assign pixels.ready  = en;
	assign acc           = pixels.valid && en;
	assign acc_pix       = acc && (pixels.action == ACT_PIXEL);

	// position of this pixel and of the next one, slot tracks row mod lines
	always_comb begin
		cw  = DIM_W'(col_q);
		rw  = DIM_W'(row_q);
		sl  = slot_q;
		if (cw >= w_eff) begin
			cw = '0;
			rw = rw + DIM_W'(1);
			sl = (sl == SLOT_W'(LINES - 1)) ? '0 : sl + SLOT_W'(1);
		end
		if (rw >= h_eff) begin
			rw = '0;
			sl = '0;
		end
		nc  = cw + DIM_W'(1);
		nr  = rw;
		nsl = sl;
		if (nc >= w_eff) begin
			nc  = '0;
			nr  = rw + DIM_W'(1);
			nsl = (sl == SLOT_W'(LINES - 1)) ? '0 : sl + SLOT_W'(1);
			if (nr >= h_eff) begin
				nr  = '0;
				nsl = '0;
			end
		end
		emit_c    = (rw + DIM_W'(1) >= k7) && (cw + DIM_W'(1) >= k7);
		tag_c.row = POS_W'(rw + DIM_W'(1) - k7 + (k7 >> 1));
		tag_c.col = POS_W'(cw + DIM_W'(1) - k7 + (k7 >> 1));
		tag_c.done = (rw + DIM_W'(1) == h_eff) && (cw + DIM_W'(1) == w_eff);
		pix_c     = pixels.sample[SMP_W-1] ? '0 : pixels.sample[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (acc_pix) begin
			row_q  <= nr[POS_W-1:0];
			col_q  <= nc[POS_W-1:0];
			slot_q <= nsl;
		end
	end

	wcf_line_buf u_line_buf (
		.clk     (clk),
		.wr_en   (acc_pix),
		.wr_col  (cw[POS_W-1:0]),
		.wr_slot (sl),
		.wr_data (pix_c),
		.rd_en   (acc),
		.rd_col  (cw[POS_W-1:0]),
		.rd_data (rd_s1)
	);

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1  <= pixels.action;
			cidx_s1 <= pixels.coef_index;
			coef_s1 <= pixels.sample;
			pix_s1  <= pix_c;
			slot_s1 <= sl;
			emit_s1 <= emit_c && (pixels.action == ACT_PIXEL);
			tag_s1  <= tag_c;
		end
	end

	// new window column: newest pixel on top, older rows from the line store
	always_comb begin
		newcol[0] = pix_s1;
		for (int q = 1; q < TAPS; q++) begin
			if (slot_s1 >= SLOT_W'(q)) begin
				newcol[q] = rd_s1[slot_s1 - SLOT_W'(q)];
			end else begin
				newcol[q] = rd_s1[slot_s1 + SLOT_W'(LINES - q)];
			end
		end
	end

	// window indexed by row age and column age, zero is newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < TAPS; q++) begin
				for (int p = 0; p < TAPS; p++) begin
					window_q[q][p] <= '0;
				end
			end
		end else if (en && valid_s1 && act_s1 == ACT_PIXEL) begin
			for (int q = 0; q < TAPS; q++) begin
				for (int p = TAPS - 1; p > 0; p--) begin
					window_q[q][p] <= window_q[q][p-1];
				end
				window_q[q][0] <= newcol[q];
			end
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2  <= act_s1;
			cidx_s2 <= cidx_s1;
			coef_s2 <= coef_s1;
			emit_s2 <= emit_s1;
			tag_s2  <= tag_s1;
		end
	end

	// coefficient writes land here, in order with the pixels around them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (en && valid_s2 && act_s2 == ACT_COEF && cidx_s2 < CIDX_W'(NCOEF)) begin
			coef_q[cidx_s2] <= coef_s2;
		end
	end

	// age (q,p) meets coefficient (q,p) for convolution, (k-1-q,k-1-p) otherwise
	// lanes outside the kernel carry zero pixel and zero coefficient
	always_comb begin
		int ki;
		ki = int'(k_eff);
		for (int q = 0; q < TAPS; q++) begin
			for (int p = 0; p < TAPS; p++) begin
				if (q >= ki || p >= ki) begin
					lane_coef[q][p] = '0;
					win_c[q][p]     = '0;
				end else if (flip_q) begin
					lane_coef[q][p] = coef_q[CIDX_W'((ki - 1 - q) * TAPS + (ki - 1 - p))];
					win_c[q][p]     = window_q[q][p];
				end else begin
					lane_coef[q][p] = coef_q[CIDX_W'(q * TAPS + p)];
					win_c[q][p]     = window_q[q][p];
				end
			end
		end
	end

	wcf_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (valid_s2 && act_s2 == ACT_PIXEL && emit_s2),
		.in_tag       (tag_s2),
		.win          (win_c),
		.lane_coef    (lane_coef),
		.out_valid    (mac_valid),
		.out_filtered (mac_filtered),
		.out_tag      (mac_tag)
	);

	assign results.valid      = mac_valid;
	assign results.filtered   = mac_filtered;
	assign results.out_row    = mac_tag.row;
	assign results.out_col    = mac_tag.col;
	assign results.frame_done = mac_tag.done;

`ifndef NO_ASSERTIONS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < SLOT_W'(LINES))
		else $error("line slot out of range");

	a_slot_row0: assert property (@(posedge clk) disable iff (!arst_n)
		row_q == '0 |-> slot_q == '0)
		else $error("line slot not aligned to row zero");

	a_coef_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && act_s1 == ACT_COEF |-> !emit_s1)
		else $error("coefficient write marked to emit");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s2) && $stable(valid_s1))
		else $error("pipeline moved during stall");
`endif

endmodule
